/* src/smx_pkg.sv */
`default_nettype none
package smx_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int OPND_W      = 16;

  localparam int DIV_MAG_W   = OPND_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_MAG_W + 1);

  localparam int CMD_W       = 3;
  localparam int ERR_W       = 2;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOP   = 3'd0,
    CMD_HALT  = 3'd1,
    CMD_ALERT = 3'd2,
    CMD_PUSH  = 3'd3,
    CMD_ADD   = 3'd4,
    CMD_SUB   = 3'd5,
    CMD_MUL   = 3'd6,
    CMD_DIV   = 3'd7
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_DIVZERO   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP
  } act_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* src/smx_ram.sv */
`default_nettype none
module smx_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/smx_div.sv */
`default_nettype none
module smx_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [smx_pkg::OPND_W-1:0]        dividend,
  input  wire logic [smx_pkg::OPND_W-1:0]        divisor,
  output logic                                   done,
  output logic      [smx_pkg::DATA_W-1:0]        quotient
);

  logic                              busy;
  logic [smx_pkg::DIV_CNT_W-1:0]     cnt;
  logic [smx_pkg::DIV_MAG_W-1:0]     rem;
  logic [smx_pkg::DIV_MAG_W-1:0]     quo;
  logic [smx_pkg::DIV_MAG_W-1:0]     dvs;
  logic                              neg;

  logic [smx_pkg::DIV_MAG_W-1:0]     a_ext;
  logic [smx_pkg::DIV_MAG_W-1:0]     b_ext;
  logic [smx_pkg::DIV_MAG_W-1:0]     a_mag;
  logic [smx_pkg::DIV_MAG_W-1:0]     b_mag;
  logic [smx_pkg::DIV_MAG_W-1:0]     rem_sh;
  logic [smx_pkg::DIV_MAG_W:0]       diff;
  logic [smx_pkg::DATA_W-1:0]        q_wide;

  assign a_ext  = {dividend[smx_pkg::OPND_W-1], dividend};
  assign b_ext  = {divisor[smx_pkg::OPND_W-1], divisor};
  assign a_mag  = dividend[smx_pkg::OPND_W-1] ? (smx_pkg::DIV_MAG_W'(0) - a_ext) : a_ext;
  assign b_mag  = divisor[smx_pkg::OPND_W-1] ? (smx_pkg::DIV_MAG_W'(0) - b_ext) : b_ext;
  assign rem_sh = {rem[smx_pkg::DIV_MAG_W-2:0], quo[smx_pkg::DIV_MAG_W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvs};
  assign q_wide = smx_pkg::DATA_W'(quo);
  assign quotient = neg ? (smx_pkg::DATA_W'(0) - q_wide) : q_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= smx_pkg::DIV_CNT_W'(smx_pkg::DIV_MAG_W);
      end else if (busy) begin
        cnt <= cnt - smx_pkg::DIV_CNT_W'(1);
        if (cnt == smx_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= a_mag;
      dvs <= b_mag;
      neg <= dividend[smx_pkg::OPND_W-1] ^ divisor[smx_pkg::OPND_W-1];
    end else if (busy) begin
      if (!diff[smx_pkg::DIV_MAG_W]) begin
        rem <= diff[smx_pkg::DIV_MAG_W-1:0];
        quo <= {quo[smx_pkg::DIV_MAG_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[smx_pkg::DIV_MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* src/stack_machine_executor_unit.sv */
// Channel   Direction  Ports                       Payload
// s_*       in         tvalid tready tdata tuser   tdata: push_value; tuser: cmd
// m_*       out        tvalid tready tdata         top_value, halted, alert_seen, error_code
//
// One instruction at a time: nop, halt, alert and push go straight to the result step;
// add, sub and mul add one stack memory read, div also the 17-step radix-2 divider.
// The top entry is held in a register; the second entry comes from the stack memory.
// Reset empties the stack and clears the halt flag; the memory itself is not cleared.
// A result waits in the output register; the next instruction is taken meanwhile and
// holds at its last step until the output register frees.
`default_nettype none
module stack_machine_executor_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [smx_pkg::DATA_W-1:0]           s_tdata,  // [31:0] push_value
  input  wire logic [smx_pkg::CMD_W-1:0]            s_tuser,  // [2:0] cmd
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic      [smx_pkg::OUT_TDATA_W-1:0]      m_tdata   // [31:0] top_value, [32] halted,
                                                              // [33] alert_seen, [35:34] error_code
);

  smx_pkg::state_t                   state;
  smx_pkg::state_t                   state_next;

  logic [smx_pkg::DEPTH_W-1:0]       depth;
  logic                              halt_flag;
  logic [smx_pkg::DATA_W-1:0]        top;

  smx_pkg::cmd_t                     cmd_q;
  smx_pkg::err_t                     err_q;
  smx_pkg::act_t                     act;
  logic [smx_pkg::DATA_W-1:0]        res;
  logic                              alert_q;
  logic                              halt_set;

  logic [smx_pkg::DATA_W-1:0]        out_top;
  logic                              out_halted;
  logic                              out_alert;
  smx_pkg::err_t                     out_err;

  logic                              ram_we;
  logic [smx_pkg::ADDR_W-1:0]        ram_waddr;
  logic                              ram_re;
  logic [smx_pkg::ADDR_W-1:0]        ram_raddr;
  logic [smx_pkg::DATA_W-1:0]        ram_rdata;

  logic                              div_start;
  logic                              div_done;
  logic [smx_pkg::DATA_W-1:0]        div_q;

  logic                              accept;
  logic                              commit;
  logic [smx_pkg::DEPTH_W-1:0]       second_idx;
  logic [smx_pkg::DEPTH_W-1:0]       depth_new;
  logic [smx_pkg::DATA_W-1:0]        top_new;

  logic signed [smx_pkg::OPND_W-1:0] opa;
  logic signed [smx_pkg::OPND_W-1:0] opb;
  logic signed [smx_pkg::DATA_W-1:0] opa_w;
  logic signed [smx_pkg::DATA_W-1:0] opb_w;
  logic signed [smx_pkg::DATA_W-1:0] mul_res;
  smx_pkg::cmd_t                     in_cmd;

  assign in_cmd     = smx_pkg::cmd_t'(s_tuser);
  assign second_idx = depth - smx_pkg::DEPTH_W'(2);
  assign opa        = ram_rdata[smx_pkg::OPND_W-1:0];
  assign opb        = top[smx_pkg::OPND_W-1:0];
  assign opa_w      = smx_pkg::DATA_W'(opa);
  assign opb_w      = smx_pkg::DATA_W'(opb);
  assign mul_res    = opa * opb;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    case (act)
      smx_pkg::ACT_PUSH: depth_new = depth + smx_pkg::DEPTH_W'(1);
      smx_pkg::ACT_POP:  depth_new = depth - smx_pkg::DEPTH_W'(1);
      default:           depth_new = depth;
    endcase
    top_new = (act == smx_pkg::ACT_NONE) ? top : res;
  end

  smx_ram #(
    .WIDTH (smx_pkg::DATA_W),
    .DEPTH (smx_pkg::STACK_DEPTH),
    .ADDR_W(smx_pkg::ADDR_W)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(res),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  smx_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(opa),
    .divisor (opb),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smx_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = second_idx[smx_pkg::ADDR_W-1:0];
    ram_we     = 1'b0;
    ram_waddr  = (act == smx_pkg::ACT_PUSH) ? depth[smx_pkg::ADDR_W-1:0]
                                            : second_idx[smx_pkg::ADDR_W-1:0];
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      smx_pkg::S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = smx_pkg::S_DONE;
          if (!halt_flag && in_cmd inside {smx_pkg::CMD_ADD, smx_pkg::CMD_SUB,
                                           smx_pkg::CMD_MUL, smx_pkg::CMD_DIV} &&
              depth >= smx_pkg::DEPTH_W'(2)) begin
            ram_re     = 1'b1;
            state_next = smx_pkg::S_READ;
          end
        end
      end
      smx_pkg::S_READ: begin
        state_next = smx_pkg::S_DONE;
        if (cmd_q == smx_pkg::CMD_DIV && opb != '0) begin
          div_start  = 1'b1;
          state_next = smx_pkg::S_DIV;
        end
      end
      smx_pkg::S_DIV: begin
        if (div_done) begin
          state_next = smx_pkg::S_DONE;
        end
      end
      smx_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          ram_we     = (act != smx_pkg::ACT_NONE);
          state_next = smx_pkg::S_IDLE;
        end
      end
      default: state_next = smx_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      smx_pkg::S_IDLE: begin
        if (accept) begin
          cmd_q    <= in_cmd;
          err_q    <= smx_pkg::ERR_OK;
          act      <= smx_pkg::ACT_NONE;
          alert_q  <= 1'b0;
          halt_set <= 1'b0;
          res      <= s_tdata;
          if (!halt_flag) begin
            case (in_cmd)
              smx_pkg::CMD_NOP:   ;
              smx_pkg::CMD_HALT:  halt_set <= 1'b1;
              smx_pkg::CMD_ALERT: alert_q <= 1'b1;
              smx_pkg::CMD_PUSH: begin
                if (depth >= smx_pkg::DEPTH_W'(smx_pkg::STACK_DEPTH)) begin
                  err_q <= smx_pkg::ERR_OVERFLOW;
                end else begin
                  act <= smx_pkg::ACT_PUSH;
                end
              end
              default: begin
                if (depth < smx_pkg::DEPTH_W'(2)) begin
                  err_q <= smx_pkg::ERR_UNDERFLOW;
                end
              end
            endcase
          end
        end
      end
      smx_pkg::S_READ: begin
        act <= smx_pkg::ACT_POP;
        case (cmd_q)
          smx_pkg::CMD_ADD: res <= opa_w + opb_w;
          smx_pkg::CMD_SUB: res <= opa_w - opb_w;
          smx_pkg::CMD_MUL: res <= mul_res;
          default: begin
            if (opb == '0) begin
              res   <= '0;
              err_q <= smx_pkg::ERR_DIVZERO;
            end
          end
        endcase
      end
      smx_pkg::S_DIV: begin
        if (div_done) begin
          res <= div_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      halt_flag <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (commit) begin
        depth     <= depth_new;
        halt_flag <= halt_flag | halt_set;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      top        <= top_new;
      out_top    <= (depth_new == '0) ? '0 : top_new;
      out_halted <= halt_flag | halt_set;
      out_alert  <= alert_q;
      out_err    <= err_q;
    end
  end

  assign m_tdata = {4'b0000, out_err, out_alert, out_halted, out_top};

endmodule
`default_nettype wire

/* test/stack_machine_executor_unit_tb.sv */
`timescale 1ns / 100ps

module stack_machine_executor_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    smx_pkg::err_t error_code;
    logic          alert_seen;
    logic          halted;
    logic [31:0]   top_value;
  } outcome_t;

  class exec_tracker;
    logic [31:0] stack_copy [smx_pkg::STACK_DEPTH];
    int          depth;
    bit          stopped;
    outcome_t    due_results [$];
    int          mismatches;
    int          checked;
    int          peak_depth;
    int          ops_seen [8];
    int          errs_seen [4];

    function new();
      depth = 0;
      stopped = 0;
      mismatches = 0;
      checked = 0;
      peak_depth = 0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
      foreach (errs_seen[i]) errs_seen[i] = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    function void take_instruction(smx_pkg::cmd_t op, logic [31:0] value);
      outcome_t o;
      int       a;
      int       b;
      int       r;
      o = '0;
      ops_seen[op]++;
      if (!stopped) begin
        case (op)
          smx_pkg::CMD_HALT: stopped = 1;
          smx_pkg::CMD_ALERT: o.alert_seen = 1'b1;
          smx_pkg::CMD_PUSH: begin
            if (depth >= smx_pkg::STACK_DEPTH) begin
              o.error_code = smx_pkg::ERR_OVERFLOW;
            end else begin
              stack_copy[depth] = value;
              depth++;
            end
          end
          smx_pkg::CMD_ADD, smx_pkg::CMD_SUB, smx_pkg::CMD_MUL, smx_pkg::CMD_DIV: begin
            if (depth < 2) begin
              o.error_code = smx_pkg::ERR_UNDERFLOW;
            end else begin
              b = $signed(stack_copy[depth-1][15:0]);
              a = $signed(stack_copy[depth-2][15:0]);
              case (op)
                smx_pkg::CMD_ADD: r = a + b;
                smx_pkg::CMD_SUB: r = a - b;
                smx_pkg::CMD_MUL: r = a * b;
                default: begin
                  if (b == 0) begin
                    r = 0;
                    o.error_code = smx_pkg::ERR_DIVZERO;
                  end else begin
                    r = a / b;
                  end
                end
              endcase
              stack_copy[depth-2] = r;
              depth--;
            end
          end
          default: ;
        endcase
      end
      if (depth > peak_depth) peak_depth = depth;
      errs_seen[o.error_code]++;
      o.halted = stopped;
      o.top_value = (depth == 0) ? 32'd0 : stack_copy[depth-1];
      due_results.push_back(o);
    endfunction

    task check_result(logic [smx_pkg::OUT_TDATA_W-1:0] word);
      outcome_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %010h with nothing pending", word));
      end else begin
        want = due_results.pop_front();
        checked++;
        if (word[31:0] !== want.top_value)
          report($sformatf("top_value got %08h want %08h", word[31:0], want.top_value));
        if (word[32] !== want.halted)
          report($sformatf("halted got %b want %b", word[32], want.halted));
        if (word[33] !== want.alert_seen)
          report($sformatf("alert_seen got %b want %b", word[33], want.alert_seen));
        if (word[35:34] !== want.error_code)
          report($sformatf("error_code got %0d want %0d", word[35:34], want.error_code));
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [smx_pkg::DATA_W-1:0]      s_tdata = '0;
  logic [smx_pkg::CMD_W-1:0]       s_tuser = smx_pkg::CMD_NOP;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [smx_pkg::OUT_TDATA_W-1:0] m_tdata;

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          cycle_count = 0;
  exec_tracker tracker = new();

  stack_machine_executor_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        tracker.take_instruction(smx_pkg::cmd_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stack_machine_executor_unit regression: fail");
      $finish;
    end
  end

  task send(smx_pkg::cmd_t op, logic [31:0] value);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [15:0] corner [5] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
    logic [31:0] raw;
    int unsigned roll;
    raw = $urandom();
    roll = $urandom_range(99);
    if (roll < 30) raw[15:0] = corner[$urandom_range(4)];
    else if (roll < 45) raw[15:0] = 16'($urandom_range(64)) - 16'd32;
    return raw;
  endfunction

  task issue_random();
    int unsigned roll;
    roll = $urandom_range(99);
    if (tracker.depth < 2 && roll < 70) send(smx_pkg::CMD_PUSH, pick_value());
    else if (roll < 40) send(smx_pkg::CMD_PUSH, pick_value());
    else if (roll < 85)
      send(smx_pkg::cmd_t'($urandom_range(smx_pkg::CMD_ADD, smx_pkg::CMD_DIV)), $urandom());
    else if (roll < 93) send(smx_pkg::CMD_NOP, $urandom());
    else send(smx_pkg::CMD_ALERT, $urandom());
  endtask

  initial begin
    int arith_count;
    int total_count;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 0;
    sink_stall_pct = 0;
    send(smx_pkg::CMD_NOP, 32'd0);
    send(smx_pkg::CMD_ADD, 32'hFFFF_FFFF);
    send(smx_pkg::CMD_PUSH, 32'hFFFF_8000);
    send(smx_pkg::CMD_DIV, 32'd0);
    send(smx_pkg::CMD_PUSH, 32'h0000_FFFF);
    send(smx_pkg::CMD_DIV, 32'd0);
    send(smx_pkg::CMD_PUSH, 32'h1234_0000);
    send(smx_pkg::CMD_DIV, 32'd0);
    send(smx_pkg::CMD_PUSH, 32'h0000_7FFF);
    send(smx_pkg::CMD_PUSH, 32'h7FFF_7FFF);
    send(smx_pkg::CMD_MUL, 32'd0);
    send(smx_pkg::CMD_SUB, 32'd0);
    send(smx_pkg::CMD_PUSH, 32'h8000_0000);
    send(smx_pkg::CMD_SUB, 32'd0);
    send(smx_pkg::CMD_PUSH, 32'hFFFF_8000);
    send(smx_pkg::CMD_PUSH, 32'hFFFF_8000);
    send(smx_pkg::CMD_MUL, 32'd0);
    send(smx_pkg::CMD_ADD, 32'd0);
    send(smx_pkg::CMD_PUSH, 32'hFFFF_8000);
    send(smx_pkg::CMD_PUSH, 32'hFFFF_8000);
    send(smx_pkg::CMD_ADD, 32'd0);
    send(smx_pkg::CMD_PUSH, 32'h0000_7FFF);
    send(smx_pkg::CMD_SUB, 32'd0);
    send(smx_pkg::CMD_ALERT, 32'hFFFF_FFFF);
    send(smx_pkg::CMD_NOP, 32'hFFFF_FFFF);
    repeat (110) issue_random();

    src_idle_pct = 58;
    sink_stall_pct = 0;
    repeat (110) issue_random();

    // fill the stack, then push past the top
    src_idle_pct = 0;
    sink_stall_pct = 58;
    while (tracker.depth < smx_pkg::STACK_DEPTH) send(smx_pkg::CMD_PUSH, pick_value());
    repeat (3) send(smx_pkg::CMD_PUSH, pick_value());
    repeat (110) issue_random();

    src_idle_pct = 29;
    sink_stall_pct = 29;
    repeat (110) issue_random();
    send(smx_pkg::CMD_HALT, $urandom());
    repeat (10)
      send(smx_pkg::cmd_t'($urandom_range(smx_pkg::CMD_NOP, smx_pkg::CMD_DIV)), $urandom());
    s_tvalid <= 1'b0;

    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    arith_count = tracker.ops_seen[smx_pkg::CMD_ADD] + tracker.ops_seen[smx_pkg::CMD_SUB]
                  + tracker.ops_seen[smx_pkg::CMD_MUL] + tracker.ops_seen[smx_pkg::CMD_DIV];
    total_count = arith_count + tracker.ops_seen[smx_pkg::CMD_NOP]
                  + tracker.ops_seen[smx_pkg::CMD_HALT] + tracker.ops_seen[smx_pkg::CMD_ALERT]
                  + tracker.ops_seen[smx_pkg::CMD_PUSH];
    $display("run covered %0d instructions: %0d push, %0d arithmetic, %0d alert, %0d halt",
             total_count, tracker.ops_seen[smx_pkg::CMD_PUSH], arith_count,
             tracker.ops_seen[smx_pkg::CMD_ALERT], tracker.ops_seen[smx_pkg::CMD_HALT]);
    $display("%0d results, stack peak %0d, %0d underflow, %0d overflow, %0d div by zero",
             tracker.checked, tracker.peak_depth,
             tracker.errs_seen[smx_pkg::ERR_UNDERFLOW],
             tracker.errs_seen[smx_pkg::ERR_OVERFLOW],
             tracker.errs_seen[smx_pkg::ERR_DIVZERO]);
    if (tracker.mismatches == 0) begin
      $display("stack_machine_executor_unit regression: pass");
    end else begin
      $display("stack_machine_executor_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/smx_pkg.sv
src/smx_ram.sv
src/smx_div.sv
src/stack_machine_executor_unit.sv
test/stack_machine_executor_unit_tb.sv
